// ===== src/mrumtf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mrumtf_pkg;

   // Fixed field widths of the request and response beats.
   localparam int REQ_TYPE_W = 2;
   localparam int POS_W      = 4;
   localparam int CNT_OUT_W  = 5;
   localparam int CSR_W      = 5;

   // Request kinds carried in req_tuser.
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD     = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PROMOTE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ    = 2'd3;

   // Capacity after reset.
   localparam int CAP_RESET = 8;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;   // latch the request beat
      logic exec;   // update the list and load the response register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_busy;   // response register holds a beat that is not taken this cycle
   } stat_type;

endpackage

`default_nettype wire

// ===== src/mru_list_move_to_front_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Beat contents
// req_      in         req_tvalid/req_tready  tdata: key, position; tuser: request kind
// rsp_      out        rsp_tvalid/rsp_tready  tdata: ok, hit, found_position, key_out, count
// csr_      in         csr_tvalid/csr_tready  tdata: capacity (always ready)
//
// Each request is handled in turn: the beat is captured in ST_IDLE, and in ST_EXEC the
// whole row of cells is compared in parallel and shifted, and the response register loads.
// If the response register still holds an untaken beat, the update waits for it.
// Reset empties the list and sets the capacity to eight (or the built depth if smaller).
// A capacity write also empties the list.

module mru_list_move_to_front_core
   import mrumtf_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS    = 32
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // key in [KEY_BITS-1:0], position above it, zero padded to bytes
   input  wire logic [((KEY_BITS + POS_W + 7) / 8) * 8 - 1:0] req_tdata,
   // request kind: add, promote, remove, read
   input  wire logic [REQ_TYPE_W-1:0] req_tuser,
   input  wire logic                  req_tvalid,
   output logic                      req_tready,
   // ok [0], hit [1], found_position [5:2], key_out, count, zero padded to bytes
   output logic [((KEY_BITS + 2 + POS_W + CNT_OUT_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                  rsp_tready,
   // capacity
   input  wire logic [CSR_W-1:0]      csr_tdata,
   input  wire logic                  csr_tvalid,
   output logic                      csr_tready
);

   localparam int IN_W  = ((KEY_BITS + POS_W + 7) / 8) * 8;
   localparam int OUT_W = ((KEY_BITS + 2 + POS_W + CNT_OUT_W + 7) / 8) * 8;

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences capture and update of one request at a time.
   mrumtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the cell row, count, capacity and the response register.
   mrumtf_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BITS    (KEY_BITS),
      .IN_W        (IN_W),
      .OUT_W       (OUT_W)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

endmodule

`default_nettype wire

// ===== src/mrumtf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrumtf_ctrl
   import mrumtf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!stat.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_EXEC: begin
            cmd.exec = !stat.out_busy;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/mrumtf_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrumtf_dpath
   import mrumtf_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS    = 32,
   parameter int IN_W        = ((KEY_BITS + POS_W + 7) / 8) * 8,
   parameter int OUT_W       = ((KEY_BITS + 2 + POS_W + CNT_OUT_W + 7) / 8) * 8
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output stat_type                  stat,
   input  wire logic [IN_W-1:0]       req_tdata,
   input  wire logic [REQ_TYPE_W-1:0] req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [OUT_W-1:0]          rsp_tdata,
   input  wire logic                  csr_tvalid,
   output logic                      csr_tready,
   input  wire logic [CSR_W-1:0]      csr_tdata
);

   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int CW      = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_RST = (CAP_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CAP_RESET;

   // Latched request.
   logic [REQ_TYPE_W-1:0] kind_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [POS_W-1:0]      pos_ff;

   // List cells, position 0 is the newest entry.
   logic [KEY_BITS-1:0] cells_ff [MAX_ENTRIES];
   logic [KEY_BITS-1:0] cells_in [MAX_ENTRIES];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cap_ff, cap_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_data_ff, rsp_data_in;

   logic [MAX_ENTRIES-1:0] hit_vec;
   logic                   hit_any;
   logic [IDX_W-1:0]       hit_idx;
   logic [IDX_W-1:0]       sel_idx;
   logic [KEY_BITS-1:0]    sel_key;
   logic                   pos_ok;
   logic                   ok;
   logic                   hit;
   logic [POS_W-1:0]       found;
   logic [KEY_BITS-1:0]    key_out;

   assign csr_tready = 1'b1;
   assign stat.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Parallel compare against every valid cell, lowest position wins.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_vec[i] = (cells_ff[i] == key_ff) && (32'(i) < 32'(count_ff));
      end
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any = |hit_vec;
   assign pos_ok  = 32'(pos_ff) < 32'(count_ff);
   assign sel_idx = IDX_W'(pos_ff);
   assign sel_key = cells_ff[sel_idx];

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         cells_in[i] = cells_ff[i];
      end
      count_in = count_ff;
      ok       = 1'b0;
      hit      = 1'b0;
      found    = '0;
      key_out  = '0;
      case (kind_ff)
         REQ_ADD: begin
            // A hit rotates cells up to the hit position; a miss shifts the whole row
            // and drops the oldest cell. Either way the key lands at the front.
            for (int i = 1; i < MAX_ENTRIES; i++) begin
               if (!hit_any || (32'(i) <= 32'(hit_idx))) begin
                  cells_in[i] = cells_ff[i-1];
               end
            end
            cells_in[0] = key_ff;
            ok = 1'b1;
            if (hit_any) begin
               hit   = 1'b1;
               found = POS_W'(hit_idx);
            end else if (count_ff < cap_ff) begin
               count_in = count_ff + 1'b1;
            end
         end
         REQ_PROMOTE: begin
            if (pos_ok) begin
               for (int i = 1; i < MAX_ENTRIES; i++) begin
                  if (32'(i) <= 32'(sel_idx)) begin
                     cells_in[i] = cells_ff[i-1];
                  end
               end
               cells_in[0] = sel_key;
               ok = 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (pos_ok) begin
               for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                  if (32'(i) >= 32'(sel_idx)) begin
                     cells_in[i] = cells_ff[i+1];
                  end
               end
               count_in = count_ff - 1'b1;
               ok = 1'b1;
            end
         end
         REQ_READ: begin
            if (pos_ok) begin
               key_out = sel_key;
               ok      = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // Capacity write: clamp into 1..MAX_ENTRIES.
   always_comb begin
      if (csr_tdata == '0) begin
         cap_in = CW'(1);
      end else if (32'(csr_tdata) > 32'(MAX_ENTRIES)) begin
         cap_in = CW'(MAX_ENTRIES);
      end else begin
         cap_in = CW'(csr_tdata);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_data_in = OUT_W'({CNT_OUT_W'(count_in), key_out, found, hit, ok});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CW'(CAP_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_tvalid && csr_tready) begin
            cap_ff   <= cap_in;
            count_ff <= '0;
         end else if (cmd.exec) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_tuser;
         key_ff  <= req_tdata[KEY_BITS-1:0];
         pos_ff  <= req_tdata[KEY_BITS+POS_W-1:KEY_BITS];
      end
      if (cmd.exec) begin
         rsp_data_ff <= rsp_data_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
   end

endmodule

`default_nettype wire
